/* hw/rtl/mpbct_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the mouse packet button and click tracker.
// No dependencies; imported by every module of the block.
package mpbct_pkg;

  // Position fixed point: POS_FRAC_BITS fraction bits, range +/- one.
  localparam int POS_FRAC_BITS = 14;
  localparam int POS_W         = POS_FRAC_BITS + 2;
  localparam int PROD_W        = 17;  // 8-bit unsigned gain times 8-bit signed delta
  localparam int SUM_W         = ((POS_W > PROD_W) ? POS_W : PROD_W) + 1;

  localparam int CNT_W   = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_PACKET = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Button phase codes
  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_DOWN     = 2'd1;
  localparam logic [1:0] PH_PRESSED  = 2'd2;
  localparam logic [1:0] PH_UP       = 2'd3;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_CLICK_WINDOW  = 2'd0;
  localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd1;
  localparam logic [1:0] REG_HIDE_PERIOD   = 2'd2;
  localparam logic [1:0] REG_MOTION_GAIN   = 2'd3;

  localparam logic [CNT_W-1:0] RST_CLICK_WINDOW  = 16'd150;
  localparam logic [CNT_W-1:0] RST_DOUBLE_WINDOW = 16'd300;
  localparam logic [CNT_W-1:0] RST_HIDE_PERIOD   = 16'd5000;
  localparam logic [7:0]       RST_MOTION_GAIN   = 8'd41;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [CNT_W-1:0] click_window;
    logic [CNT_W-1:0] double_window;
    logic [CNT_W-1:0] hide_period;
    logic [7:0]       motion_gain;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        status_byte;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [2:0]        clear_click_mask;
    logic [2:0]        clear_double_mask;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [5:0]         phases;
    logic [2:0]         clicked;
    logic [2:0]         double_clicked;
    logic               hidden;
  } out_item_t;

endpackage

/* hw/rtl/mouse_packet_button_click_tracker.sv */
`timescale 1ns / 1ps
// Mouse packet button and click tracker, top level. Depends on mpbct_pkg,
// mpbct_cfg_regs and mpbct_core.
//
// Each request (tick, mouse packet or flag clear) is captured in an input
// register, applied to the tracker state by combinational logic and its result
// captured in an output register. One request is accepted every cycle while
// results keep draining. A stalled output holds the result; the input register
// keeps taking a request as long as it will move on at the same edge. The user
// must write configuration only while no request is in flight; the block does
// not enforce it.
module mouse_packet_button_click_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mpbct_pkg::in_item_t         in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mpbct_pkg::out_item_t        out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpbct_pkg::ADDR_W-1:0] paddr,
  input  logic [mpbct_pkg::DATA_W-1:0] pwdata,
  output logic [mpbct_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mpbct_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      s1_adv;
  out_item_t core_result;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  mpbct_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpbct_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (in_valid && in_ready) s1_item <= in_item;
    if (s1_adv) out_item <= core_result;
  end

  // a packet always leaves the pointer shown
  a_packet_shows: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.kind == KIND_PACKET |=> out_valid && !out_item.hidden)
    else $error("packet result reports hidden pointer");

  // cleared click flags read back as zero
  a_clear_click: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.kind == KIND_CLEAR |=>
      (out_item.clicked & $past(s1_item.clear_click_mask)) == 3'b000)
    else $error("clear request left a click flag set");

  a_clear_double: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.kind == KIND_CLEAR |=>
      (out_item.double_clicked & $past(s1_item.clear_double_mask)) == 3'b000)
    else $error("clear request left a double-click flag set");

  // input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

endmodule

/* hw/rtl/mpbct_cfg_regs.sv */
`timescale 1ns / 1ps
// APB-style register file: click/double windows, hide period, motion gain.
// Depends on mpbct_pkg.
module mpbct_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpbct_pkg::ADDR_W-1:0] paddr,
  input  logic [mpbct_pkg::DATA_W-1:0] pwdata,
  output logic [mpbct_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mpbct_pkg::cfg_t             cfg
);
  import mpbct_pkg::*;

  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_window  <= RST_CLICK_WINDOW;
      cfg.double_window <= RST_DOUBLE_WINDOW;
      cfg.hide_period   <= RST_HIDE_PERIOD;
      cfg.motion_gain   <= RST_MOTION_GAIN;
    end else if (wr_en) begin
      unique case (idx)
        REG_CLICK_WINDOW:  cfg.click_window  <= pwdata[CNT_W-1:0];
        REG_DOUBLE_WINDOW: cfg.double_window <= pwdata[CNT_W-1:0];
        REG_HIDE_PERIOD:   cfg.hide_period   <= pwdata[CNT_W-1:0];
        REG_MOTION_GAIN:   cfg.motion_gain   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLICK_WINDOW:  prdata = DATA_W'(cfg.click_window);
      REG_DOUBLE_WINDOW: prdata = DATA_W'(cfg.double_window);
      REG_HIDE_PERIOD:   prdata = DATA_W'(cfg.hide_period);
      REG_MOTION_GAIN:   prdata = DATA_W'(cfg.motion_gain);
      default:           prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/mpbct_core.sv */
`timescale 1ns / 1ps
// Tracker state and its combinational update: position clamp, button machines,
// click timing and hide timer. Depends on mpbct_pkg.
module mpbct_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  mpbct_pkg::in_item_t  item,
  input  mpbct_pkg::cfg_t      cfg,
  output mpbct_pkg::out_item_t result
);
  import mpbct_pkg::*;

  localparam int                      ONE_I    = 1 << POS_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SUM_ONE  = SUM_W'(ONE_I);
  localparam logic signed [SUM_W-1:0] SUM_MONE = -SUM_ONE;

  pos_t             x_pos, y_pos, x_pos_next, y_pos_next;
  logic [1:0]       btn_phase [3];
  logic [1:0]       btn_phase_next [3];
  logic [2:0]       click_latch, click_latch_next;
  logic [2:0]       dbl_latch, dbl_latch_next;
  logic [CNT_W-1:0] since_press, since_press_next;
  logic [CNT_W-1:0] since_click, since_click_next;
  logic [CNT_W-1:0] hide_count, hide_count_next;
  logic             hidden_flag, hidden_flag_next;
  logic [CNT_W:0]   hide_inc;
  logic [2:0]       btn_p;

  function automatic pos_t move_clamp(pos_t pos, logic [7:0] gain,
                                      logic signed [7:0] delta);
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    prod = $signed({1'b0, gain}) * delta;
    sum  = SUM_W'(pos) + SUM_W'(prod);
    if (sum < SUM_MONE) sum = SUM_MONE;
    if (sum > SUM_ONE)  sum = SUM_ONE;
    return POS_W'(sum);
  endfunction

  // left, middle, right; status byte has right in bit1 and middle in bit2
  assign btn_p    = {item.status_byte[1], item.status_byte[2], item.status_byte[0]};
  assign hide_inc = {1'b0, hide_count} + (CNT_W + 1)'(1);

  always_comb begin
    logic rel;
    x_pos_next       = x_pos;
    y_pos_next       = y_pos;
    btn_phase_next   = btn_phase;
    click_latch_next = click_latch;
    dbl_latch_next   = dbl_latch;
    since_press_next = since_press;
    since_click_next = since_click;
    hide_count_next  = hide_count;
    hidden_flag_next = hidden_flag;
    rel              = 1'b0;
    if (step) begin
      unique case (item.kind)
        KIND_TICK: begin
          if (since_press != '1) since_press_next = since_press + CNT_W'(1);
          if (since_click != '1) since_click_next = since_click + CNT_W'(1);
          if (hide_inc >= {1'b0, cfg.hide_period}) begin
            hide_count_next  = '0;
            hidden_flag_next = 1'b1;
          end else begin
            hide_count_next = hide_inc[CNT_W-1:0];
          end
        end
        KIND_PACKET: begin
          x_pos_next = move_clamp(x_pos, cfg.motion_gain, item.delta_x);
          y_pos_next = move_clamp(y_pos, cfg.motion_gain, item.delta_y);
          // buttons share the press/click timers, so evaluate in order
          for (int b = 0; b < 3; b++) begin
            rel = 1'b0;
            unique case (btn_phase[b])
              PH_RELEASED: begin
                if (btn_p[b]) begin
                  btn_phase_next[b] = PH_DOWN;
                  since_press_next  = '0;
                end
              end
              PH_DOWN: begin
                btn_phase_next[b] = btn_p[b] ? PH_PRESSED : PH_RELEASED;
                rel = !btn_p[b];
              end
              PH_PRESSED: begin
                if (!btn_p[b]) btn_phase_next[b] = PH_UP;
              end
              PH_UP: begin
                btn_phase_next[b] = btn_p[b] ? PH_PRESSED : PH_RELEASED;
                rel = !btn_p[b];
              end
              default: ;
            endcase
            if (rel && since_press_next <= cfg.click_window) begin
              click_latch_next[b] = 1'b1;
              if (since_click_next <= cfg.double_window) dbl_latch_next[b] = 1'b1;
              since_click_next = '0;
            end
          end
          hidden_flag_next = 1'b0;
        end
        KIND_CLEAR: begin
          click_latch_next = click_latch & ~item.clear_click_mask;
          dbl_latch_next   = dbl_latch & ~item.clear_double_mask;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos       <= '0;
      y_pos       <= '0;
      btn_phase   <= '{PH_RELEASED, PH_RELEASED, PH_RELEASED};
      click_latch <= '0;
      dbl_latch   <= '0;
      since_press <= '0;
      since_click <= '0;
      hide_count  <= '0;
      hidden_flag <= 1'b1;
    end else begin
      x_pos       <= x_pos_next;
      y_pos       <= y_pos_next;
      btn_phase   <= btn_phase_next;
      click_latch <= click_latch_next;
      dbl_latch   <= dbl_latch_next;
      since_press <= since_press_next;
      since_click <= since_click_next;
      hide_count  <= hide_count_next;
      hidden_flag <= hidden_flag_next;
    end
  end

  always_comb begin
    result.pos_x          = 16'(x_pos_next);
    result.pos_y          = 16'(y_pos_next);
    result.phases         = {btn_phase_next[2], btn_phase_next[1], btn_phase_next[0]};
    result.clicked        = click_latch_next;
    result.double_clicked = dbl_latch_next;
    result.hidden         = hidden_flag_next;
  end

endmodule

/* bench/tb_mouse_packet_button_click_tracker.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mouse_packet_button_click_tracker: directed table,
// random click sequences over several register settings, closing back-to-back run.
// Depends on mpbct_pkg and the block's RTL only.
module tb_mouse_packet_button_click_tracker;
  import mpbct_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 4;
  localparam int CNT_LIMIT    = (1 << CNT_W) - 1;
  localparam logic [1:0] KIND_NONE = 2'd3;  // unused kind, reports state only

  localparam int BTN_LEFT   = 0;
  localparam int BTN_MIDDLE = 1;
  localparam int BTN_RIGHT  = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mouse_packet_button_click_tracker u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker state as the block should hold it
  int click_win = int'(RST_CLICK_WINDOW);
  int dbl_win   = int'(RST_DOUBLE_WINDOW);
  int hide_per  = int'(RST_HIDE_PERIOD);
  int gain      = int'(RST_MOTION_GAIN);
  int x_pos = 0;
  int y_pos = 0;
  logic [1:0] phase_st [3] = '{default: PH_RELEASED};
  logic [2:0] click_flags = '0;
  logic [2:0] dbl_flags = '0;
  int since_press = 0;
  int since_click = 0;
  int hide_cnt = 0;
  logic hidden_st = 1'b1;

  out_item_t pending_results[$];
  int error_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int stall_left = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  logic [2:0] held_buttons = '0;  // status bit order: left, right, middle

  typedef struct {
    in_item_t  req;
    bit        known;
    out_item_t result;
  } plan_row_t;
  plan_row_t directed_plan[$];

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic int move_clamped(input int pos, input logic signed [7:0] delta);
    int unit_one;
    int r;
    unit_one = 1 << POS_FRAC_BITS;
    r = pos + gain * int'(delta);
    if (r < -unit_one) r = -unit_one;
    if (r > unit_one) r = unit_one;
    return r;
  endfunction

  function automatic void settle_click(input int b);
    if (since_press <= click_win) begin
      click_flags[b] = 1'b1;
      if (since_click <= dbl_win) dbl_flags[b] = 1'b1;
      since_click = 0;
    end
  endfunction

  function automatic void step_button(input int b, input bit held);
    case (phase_st[b])
      PH_RELEASED: if (held) begin
        phase_st[b] = PH_DOWN;
        since_press = 0;
      end
      PH_DOWN: if (held) begin
        phase_st[b] = PH_PRESSED;
      end else begin
        phase_st[b] = PH_RELEASED;
        settle_click(b);
      end
      PH_PRESSED: if (!held) phase_st[b] = PH_UP;
      default: if (held) begin
        phase_st[b] = PH_PRESSED;
      end else begin
        phase_st[b] = PH_RELEASED;
        settle_click(b);
      end
    endcase
  endfunction

  function automatic out_item_t track_request(input in_item_t req);
    out_item_t res;
    case (req.kind)
      KIND_TICK: begin
        if (since_press < CNT_LIMIT) since_press++;
        if (since_click < CNT_LIMIT) since_click++;
        // a period of zero behaves as one
        if (hide_cnt + 1 >= hide_per) begin
          hide_cnt = 0;
          hidden_st = 1'b1;
        end else begin
          hide_cnt++;
        end
      end
      KIND_PACKET: begin
        x_pos = move_clamped(x_pos, req.delta_x);
        y_pos = move_clamped(y_pos, req.delta_y);
        // shared press timer: order left, middle, right matters
        step_button(BTN_LEFT, req.status_byte[0]);
        step_button(BTN_MIDDLE, req.status_byte[2]);
        step_button(BTN_RIGHT, req.status_byte[1]);
        hidden_st = 1'b0;
      end
      KIND_CLEAR: begin
        click_flags = click_flags & ~req.clear_click_mask;
        dbl_flags = dbl_flags & ~req.clear_double_mask;
      end
      default: ;
    endcase
    res.pos_x = x_pos[15:0];
    res.pos_y = y_pos[15:0];
    res.phases = {phase_st[BTN_RIGHT], phase_st[BTN_MIDDLE], phase_st[BTN_LEFT]};
    res.clicked = click_flags;
    res.double_clicked = dbl_flags;
    res.hidden = hidden_st;
    return res;
  endfunction

  task automatic send_request(input in_item_t req, input bit use_known = 1'b0,
                              input out_item_t known = '0);
    bit took;
    out_item_t got;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_item <= req;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    got = track_request(req);
    pending_results.push_back(use_known ? known : got);
    requests_sent++;
  endtask

  task automatic apb_finish(output logic [DATA_W-1:0] data);
    bit done;
    do begin
      @(negedge clk);
      done = pready;
      data = prdata;
      @(posedge clk);
    end while (!done);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    apb_finish(readback);
    // read the register back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    apb_finish(readback);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== value)
      flag_error($sformatf("reg %0d readback %0h, wrote %0h", idx, readback, value));
    case (idx)
      REG_CLICK_WINDOW:  click_win = int'(value[15:0]);
      REG_DOUBLE_WINDOW: dbl_win = int'(value[15:0]);
      REG_HIDE_PERIOD:   hide_per = int'(value[15:0]);
      REG_MOTION_GAIN:   gain = int'(value[7:0]);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [7:0] status,
                         input logic signed [7:0] dx, input logic signed [7:0] dy,
                         input logic [2:0] cmask, input logic [2:0] dmask,
                         input bit known = 1'b0,
                         input logic signed [15:0] px = '0,
                         input logic signed [15:0] py = '0,
                         input logic [5:0] ph = '0, input logic [2:0] ck = '0,
                         input logic [2:0] dc = '0, input logic hid = 1'b0);
    plan_row_t row;
    row.req = '{kind, status, dx, dy, cmask, dmask};
    row.known = known;
    row.result = '{px, py, ph, ck, dc, hid};
    directed_plan.push_back(row);
  endtask

  task automatic random_requests(input int count);
    in_item_t req;
    int sent;
    int roll;
    int burst;
    sent = 0;
    while (sent < count) begin
      req = in_item_t'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        req.kind = KIND_TICK;
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : 1;
        repeat (burst) send_request(req);
        sent += burst;
      end else if (roll < 85) begin
        req.kind = KIND_PACKET;
        // mostly one button changes per packet, so full press/release cycles form
        if ($urandom_range(0, 3) != 0) held_buttons ^= 3'b001 << $urandom_range(0, 2);
        else held_buttons = 3'($urandom);
        req.status_byte[2:0] = held_buttons;
        if ($urandom_range(0, 1) == 0) req.status_byte[7:3] = '0;
        if ($urandom_range(0, 1) == 0) begin
          req.delta_x = $urandom_range(0, 16) - 8;
          req.delta_y = $urandom_range(0, 16) - 8;
        end
        send_request(req);
        sent++;
      end else if (roll < 96) begin
        req.kind = KIND_CLEAR;
        send_request(req);
        sent++;
      end else begin
        req.kind = KIND_NONE;
        send_request(req);
      end
    end
  endtask

  task automatic run_setting(input int cw, input int dw, input int hp, input int g,
                             input int count, input bit idle);
    in_valid <= 1'b0;
    wait_drained();
    program_reg(REG_CLICK_WINDOW, cw);
    program_reg(REG_DOUBLE_WINDOW, dw);
    program_reg(REG_HIDE_PERIOD, hp);
    program_reg(REG_MOTION_GAIN, g);
    settings_used++;
    src_idle_on <= idle;
    sink_idle_on <= idle;
    random_requests(count);
  endtask

  // output side drops ready in random bursts while sink idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        if (out_item.pos_x !== want.pos_x || out_item.pos_y !== want.pos_y ||
            out_item.phases !== want.phases || out_item.clicked !== want.clicked ||
            out_item.double_clicked !== want.double_clicked ||
            out_item.hidden !== want.hidden)
          flag_error($sformatf(
            "result %0d: exp x=%0d y=%0d ph=%b ck=%b dc=%b hid=%b, got x=%0d y=%0d ph=%b ck=%b dc=%b hid=%b",
            results_seen, want.pos_x, want.pos_y, want.phases, want.clicked,
            want.double_clicked, want.hidden, out_item.pos_x, out_item.pos_y,
            out_item.phases, out_item.clicked, out_item.double_clicked, out_item.hidden));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("tb_mouse_packet_button_click_tracker: done, errors");
      $finish;
    end
  end

  initial begin
    in_item_t req;
    // reset register values; typed rows follow straight from them
    add_row(KIND_NONE, 8'h00, 0, 0, 3'd0, 3'd0, 1'b1, 0, 0, 6'd0, 3'd0, 3'd0, 1'b1);
    add_row(KIND_TICK, 8'h00, 0, 0, 3'd0, 3'd0, 1'b1, 0, 0, 6'd0, 3'd0, 3'd0, 1'b1);
    add_row(KIND_PACKET, 8'h01, 127, -128, 3'd0, 3'd0,
            1'b1, 5207, -5248, 6'b000001, 3'd0, 3'd0, 1'b0);
    // first click after reset also counts as a double click
    add_row(KIND_PACKET, 8'h00, 127, -128, 3'd0, 3'd0,
            1'b1, 10414, -10496, 6'd0, 3'b001, 3'b001, 1'b0);
    add_row(KIND_PACKET, 8'h00, 127, -128, 3'd0, 3'd0,
            1'b1, 15621, -15744, 6'd0, 3'b001, 3'b001, 1'b0);
    add_row(KIND_PACKET, 8'h00, 127, -128, 3'd0, 3'd0,
            1'b1, 16384, -16384, 6'd0, 3'b001, 3'b001, 1'b0);
    add_row(KIND_CLEAR, 8'hff, -1, -1, 3'b001, 3'b000,
            1'b1, 16384, -16384, 6'd0, 3'b000, 3'b001, 1'b0);
    add_row(KIND_CLEAR, 8'h00, 0, 0, 3'b000, 3'b111,
            1'b1, 16384, -16384, 6'd0, 3'b000, 3'b000, 1'b0);
    add_row(KIND_PACKET, 8'hf8, -128, 127, 3'd7, 3'd7);  // unused status bits only
    add_row(KIND_PACKET, 8'h07, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h07, 0, 0, 3'd0, 3'd0);
    add_row(KIND_TICK, 8'h00, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h00, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h00, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h02, 1, -1, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h06, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h04, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h06, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h01, 0, 0, 3'd0, 3'd0);
    add_row(KIND_PACKET, 8'h00, -1, 1, 3'd0, 3'd0);
    add_row(KIND_TICK, 8'hff, 127, 127, 3'd7, 3'd7);
    add_row(KIND_NONE, 8'hff, -128, -128, 3'd7, 3'd7);
    add_row(KIND_CLEAR, 8'h00, 0, 0, 3'b101, 3'b010);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      send_request(directed_plan[i].req, directed_plan[i].known, directed_plan[i].result);

    random_requests(100);
    run_setting(0, 0, 0, 0, 120, 1'b1);
    run_setting(65535, 65535, 65535, 255, 130, 1'b1);
    run_setting($urandom_range(0, 12), $urandom_range(0, 40), 1, $urandom_range(0, 255),
                140, 1'b1);
    repeat (3)
      run_setting($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(1, 12),
                  $urandom_range(0, 255), 140, 1'b1);
    run_setting($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(1, 12),
                $urandom_range(0, 255), 140, 1'b0);

    // closing stretch, no idling: wide windows, press held across a tick run
    run_setting(65534, 65535, 65535, 1, 0, 1'b0);
    req = '0;
    req.kind = KIND_CLEAR;
    req.clear_click_mask = 3'b111;
    req.clear_double_mask = 3'b111;
    send_request(req);
    req = '0;
    req.kind = KIND_PACKET;
    req.status_byte = 8'h01;
    send_request(req);
    req.kind = KIND_TICK;
    repeat (40) send_request(req);
    req.kind = KIND_PACKET;
    req.status_byte = 8'h00;
    send_request(req);  // release inside the wide window: click
    req.status_byte = 8'h01;
    send_request(req);
    req.status_byte = 8'h00;
    send_request(req);  // second click right after the first: double click
    in_valid <= 1'b0;

    wait_drained();
    $display("ran %0d requests, checked %0d results over %0d register settings",
             requests_sent, results_seen, settings_used);
    $display("mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("tb_mouse_packet_button_click_tracker: done, clean");
    end else begin
      $display("tb_mouse_packet_button_click_tracker: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mpbct_pkg.sv
hw/rtl/mpbct_cfg_regs.sv
hw/rtl/mpbct_core.sv
hw/rtl/mouse_packet_button_click_tracker.sv
bench/tb_mouse_packet_button_click_tracker.sv
